### rtl/ppu_rp_pkg.sv
// Shared constants, codes and types for the video processor register port.
package ppu_rp_pkg;

    localparam int VIDEO_ADDR_BITS = 14;
    localparam int VIDEO_DEPTH     = 1 << VIDEO_ADDR_BITS;
    localparam int OBJECT_DEPTH    = 256;
    localparam int OBJ_IDX_BITS    = $clog2(OBJECT_DEPTH);
    localparam int PALETTE_DEPTH   = 32;
    localparam int PAL_IDX_BITS    = $clog2(PALETTE_DEPTH);

    localparam int DOTS_PER_LINE   = 341;
    localparam int LINES_PER_FRAME = 262;
    localparam int VBLANK_LINE     = 241;
    localparam int COL_BITS        = $clog2(DOTS_PER_LINE);
    localparam int LINE_BITS       = $clog2(LINES_PER_FRAME);

    localparam logic [COL_BITS:0]    DOTS_LIMIT   = (COL_BITS + 1)'(DOTS_PER_LINE);
    localparam logic [LINE_BITS:0]   LINES_LIMIT  = (LINE_BITS + 1)'(LINES_PER_FRAME);
    localparam logic [LINE_BITS-1:0] VBLANK_ROW   = LINE_BITS'(VBLANK_LINE);
    localparam logic [LINE_BITS-1:0] PRERENDER_ROW = LINE_BITS'(LINES_PER_FRAME - 1);
    localparam logic [COL_BITS-1:0]  EVENT_COL    = COL_BITS'(1);

    localparam logic [15:0] PALETTE_BASE = 16'h3F00;
    localparam logic [15:0] VIDEO_LIMIT  = 16'h4000;
    localparam logic [15:0] STEP_NARROW  = 16'd1;
    localparam logic [15:0] STEP_WIDE    = 16'd32;

    localparam int VBLANK_BIT  = 7;
    localparam int CTRL_NMI_BIT = 7;
    localparam int CTRL_STEP_BIT = 2;

    // item modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // register numbers
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OBJ_ADDR = 3'd3;
    localparam logic [2:0] REG_OBJ_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_VADDR    = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    typedef struct packed {
        logic set_vblank;
        logic clr_vblank;
    } t_frame_evt;

endpackage

### rtl/ppu_rp_if.sv
// Channel interfaces for the register port: item input and result output.
interface ppu_rp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [2:0] reg_index;
    logic [7:0] write_data;

    modport source (output valid, output mode, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input reg_index, input write_data,
                    output ready);
endinterface

interface ppu_rp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       nmi_pulse;
    logic       access_error;

    modport source (output valid, output read_data, output nmi_pulse, output access_error,
                    input ready);
    modport sink   (input valid, input read_data, input nmi_pulse, input access_error,
                    output ready);
endinterface

### rtl/ppu_rp_ram.sv
// Generic synchronous RAM: one write port, one read port with registered data.
module ppu_rp_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/ppu_rp_timing.sv
// Dot and line counter; flags the vblank start and pre-render dots.
module ppu_rp_timing (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tick,
    output ppu_rp_pkg::t_frame_evt o_evt
);
    logic [ppu_rp_pkg::COL_BITS-1:0]  r_col, n_col;
    logic [ppu_rp_pkg::LINE_BITS-1:0] r_line, n_line;
    logic [ppu_rp_pkg::COL_BITS:0]    w_col_inc;
    logic [ppu_rp_pkg::LINE_BITS:0]   w_line_inc;

    always_comb begin
        w_col_inc  = {1'b0, r_col} + 1'b1;
        w_line_inc = {1'b0, r_line} + 1'b1;
        if (w_col_inc >= ppu_rp_pkg::DOTS_LIMIT) begin
            n_col = '0;
            if (w_line_inc >= ppu_rp_pkg::LINES_LIMIT) begin
                n_line = '0;
            end else begin
                n_line = w_line_inc[ppu_rp_pkg::LINE_BITS-1:0];
            end
        end else begin
            n_col  = w_col_inc[ppu_rp_pkg::COL_BITS-1:0];
            n_line = r_line;
        end
    end

    // events look at the position the tick moves to
    assign o_evt.set_vblank = (n_line == ppu_rp_pkg::VBLANK_ROW) &&
                              (n_col == ppu_rp_pkg::EVENT_COL);
    assign o_evt.clr_vblank = (n_line == ppu_rp_pkg::PRERENDER_ROW) &&
                              (n_col == ppu_rp_pkg::EVENT_COL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
        end else if (i_tick) begin
            r_col  <= n_col;
            r_line <= n_line;
        end
    end
endmodule

### rtl/ppu_register_port_top.sv
// Video processor register port: register file, object and video memories.
//
// Input channel i_in carries one word per item: mode (read, write, dot tick),
// reg_index and write_data. Output channel o_out returns one word per item:
// read_data, nmi_pulse and access_error, in item order.
// Latency: the result of an item is valid on the cycle after it is accepted.
// Throughput: one item per cycle outside the reset sweep and output stalls;
// object and video memories are read at accept, and object data feeds the result.
// The data-port read buffer is reloaded when a data-port read result is taken.
// Reset: synchronous, active low. After reset the video memory is swept to
// zero, one entry per cycle across all its entries, while i_in.ready stays low.
// Object memory entries read as zero until written (per-entry valid bits).
// When o_out.ready is low a held result stays and i_in.ready drops, so while
// a result is held the port takes a new word only when it leaves in the same cycle.
module ppu_register_port_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ppu_rp_in_if.sink          i_in,
    ppu_rp_out_if.source       o_out
);
    localparam logic [1:0] SEL_REG  = 2'd0;
    localparam logic [1:0] SEL_OBJ  = 2'd1;
    localparam logic [1:0] SEL_PORT = 2'd2;

    localparam int VA = ppu_rp_pkg::VIDEO_ADDR_BITS;
    localparam int OB = ppu_rp_pkg::OBJ_IDX_BITS;
    localparam int PB = ppu_rp_pkg::PAL_IDX_BITS;

    // architectural registers
    logic [7:0]  r_control, n_control;
    logic [7:0]  r_mask, n_mask;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_obj_addr, n_obj_addr;
    logic [15:0] r_scroll, n_scroll;
    logic [15:0] r_vaddr, n_vaddr;
    logic        r_toggle, n_toggle;
    logic [7:0]  r_read_buffer;
    logic [7:0]  r_palette [ppu_rp_pkg::PALETTE_DEPTH];
    logic        r_obj_valid [ppu_rp_pkg::OBJECT_DEPTH];
    logic [VA:0] r_clr_cnt;

    // result stage
    logic       r_s1_valid;
    logic [1:0] r_s1_sel, n_s1_sel;
    logic [7:0] r_s1_rd, n_s1_rd;
    logic       r_s1_nmi, n_s1_nmi;
    logic       r_s1_err, n_s1_err;
    logic       r_s1_obj_ok, n_s1_obj_ok;
    logic       r_s1_flat, n_s1_flat;
    logic [7:0] r_s1_pal, n_s1_pal;

    logic                  w_clearing;
    logic                  w_accept;
    logic                  w_out_take;
    logic                  w_tick;
    ppu_rp_pkg::t_frame_evt w_evt;
    logic                  w_is_flat;
    logic                  w_is_pal;
    logic [15:0]           w_vaddr_step;
    logic [OB-1:0]         w_obj_idx;
    logic [PB-1:0]         w_pal_idx;
    logic                  w_obj_we, w_obj_re;
    logic                  w_vid_wr, w_vid_re;
    logic                  w_pal_we, w_pal_mirror;
    logic [7:0]            w_obj_rdata, w_vid_rdata;
    logic                  w_vid_we;
    logic [VA-1:0]         w_vid_waddr;
    logic [7:0]            w_vid_wdata;

    assign w_clearing = !r_clr_cnt[VA];
    assign i_in.ready = !w_clearing && (!r_s1_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_take = o_out.valid && o_out.ready;

    assign w_is_flat    = r_vaddr < ppu_rp_pkg::PALETTE_BASE;
    assign w_is_pal     = !w_is_flat && (r_vaddr < ppu_rp_pkg::VIDEO_LIMIT);
    assign w_vaddr_step = r_vaddr + (r_control[ppu_rp_pkg::CTRL_STEP_BIT] ?
                                     ppu_rp_pkg::STEP_WIDE : ppu_rp_pkg::STEP_NARROW);
    assign w_obj_idx    = r_obj_addr[OB-1:0];
    assign w_pal_idx    = r_vaddr[PB-1:0];
    assign w_pal_mirror = (w_pal_idx[1:0] == 2'b00);

    ppu_rp_timing u_timing (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (w_tick),
        .o_evt   (w_evt)
    );

    always_comb begin
        n_control   = r_control;
        n_mask      = r_mask;
        n_status    = r_status;
        n_obj_addr  = r_obj_addr;
        n_scroll    = r_scroll;
        n_vaddr     = r_vaddr;
        n_toggle    = r_toggle;
        n_s1_sel    = SEL_REG;
        n_s1_rd     = 8'd0;
        n_s1_nmi    = 1'b0;
        n_s1_err    = 1'b0;
        n_s1_obj_ok = 1'b0;
        n_s1_flat   = 1'b0;
        n_s1_pal    = 8'd0;
        w_obj_we    = 1'b0;
        w_obj_re    = 1'b0;
        w_vid_wr    = 1'b0;
        w_vid_re    = 1'b0;
        w_pal_we    = 1'b0;
        w_tick      = 1'b0;
        if (w_accept) begin
            unique case (i_in.mode)
                ppu_rp_pkg::MODE_READ: begin
                    unique case (i_in.reg_index)
                        ppu_rp_pkg::REG_CTRL: n_s1_rd = r_control;
                        ppu_rp_pkg::REG_MASK: n_s1_rd = r_mask;
                        ppu_rp_pkg::REG_STATUS: begin
                            n_s1_rd = r_status;
                            n_status[ppu_rp_pkg::VBLANK_BIT] = 1'b0;
                            n_toggle = 1'b0;
                        end
                        ppu_rp_pkg::REG_OBJ_DATA: begin
                            n_s1_sel    = SEL_OBJ;
                            w_obj_re    = 1'b1;
                            n_s1_obj_ok = r_obj_valid[w_obj_idx];
                        end
                        ppu_rp_pkg::REG_DATA: begin
                            n_s1_sel = SEL_PORT;
                            n_vaddr  = w_vaddr_step;
                            if (w_is_flat) begin
                                w_vid_re  = 1'b1;
                                n_s1_flat = 1'b1;
                            end else if (w_is_pal) begin
                                n_s1_pal = r_palette[w_pal_idx];
                            end else begin
                                n_s1_err = 1'b1;
                            end
                        end
                        default: n_s1_err = 1'b1;   // write-only registers
                    endcase
                end
                ppu_rp_pkg::MODE_WRITE: begin
                    unique case (i_in.reg_index)
                        ppu_rp_pkg::REG_CTRL:     n_control  = i_in.write_data;
                        ppu_rp_pkg::REG_MASK:     n_mask     = i_in.write_data;
                        ppu_rp_pkg::REG_STATUS:   n_status   = i_in.write_data;
                        ppu_rp_pkg::REG_OBJ_ADDR: n_obj_addr = i_in.write_data;
                        ppu_rp_pkg::REG_OBJ_DATA: begin
                            w_obj_we   = 1'b1;
                            n_obj_addr = r_obj_addr + 8'd1;
                        end
                        ppu_rp_pkg::REG_SCROLL: begin
                            n_scroll = r_toggle ? {r_scroll[15:8], i_in.write_data}
                                                : {i_in.write_data, r_scroll[7:0]};
                            n_toggle = !r_toggle;
                        end
                        ppu_rp_pkg::REG_VADDR: begin
                            n_vaddr  = r_toggle ? {r_vaddr[15:8], i_in.write_data}
                                                : {i_in.write_data, r_vaddr[7:0]};
                            n_toggle = !r_toggle;
                        end
                        ppu_rp_pkg::REG_DATA: begin
                            n_vaddr = w_vaddr_step;
                            if (w_is_flat) begin
                                w_vid_wr = 1'b1;
                            end else if (w_is_pal) begin
                                w_pal_we = 1'b1;
                            end else begin
                                n_s1_err = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                ppu_rp_pkg::MODE_TICK: begin
                    w_tick = 1'b1;
                    if (w_evt.set_vblank) begin
                        n_status[ppu_rp_pkg::VBLANK_BIT] = 1'b1;
                        n_s1_nmi = r_control[ppu_rp_pkg::CTRL_NMI_BIT];
                    end
                    if (w_evt.clr_vblank) begin
                        n_status[ppu_rp_pkg::VBLANK_BIT] = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    ppu_rp_ram #(
        .DEPTH (ppu_rp_pkg::OBJECT_DEPTH),
        .WIDTH (8)
    ) u_obj_ram (
        .i_clk   (i_clk),
        .i_we    (w_obj_we),
        .i_waddr (w_obj_idx),
        .i_wdata (i_in.write_data),
        .i_re    (w_obj_re),
        .i_raddr (w_obj_idx),
        .o_rdata (w_obj_rdata)
    );

    // clearing sweep owns the write port after reset
    assign w_vid_we    = w_clearing || w_vid_wr;
    assign w_vid_waddr = w_clearing ? r_clr_cnt[VA-1:0] : r_vaddr[VA-1:0];
    assign w_vid_wdata = w_clearing ? 8'd0 : i_in.write_data;

    ppu_rp_ram #(
        .DEPTH (ppu_rp_pkg::VIDEO_DEPTH),
        .WIDTH (8)
    ) u_vid_ram (
        .i_clk   (i_clk),
        .i_we    (w_vid_we),
        .i_waddr (w_vid_waddr),
        .i_wdata (w_vid_wdata),
        .i_re    (w_vid_re),
        .i_raddr (r_vaddr[VA-1:0]),
        .o_rdata (w_vid_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control     <= '0;
            r_mask        <= '0;
            r_status      <= '0;
            r_obj_addr    <= '0;
            r_scroll      <= '0;
            r_vaddr       <= '0;
            r_toggle      <= 1'b0;
            r_read_buffer <= '0;
            r_clr_cnt     <= '0;
            r_s1_valid    <= 1'b0;
            for (int i = 0; i < ppu_rp_pkg::PALETTE_DEPTH; i++) begin
                r_palette[i] <= '0;
            end
            for (int i = 0; i < ppu_rp_pkg::OBJECT_DEPTH; i++) begin
                r_obj_valid[i] <= 1'b0;
            end
        end else begin
            r_control  <= n_control;
            r_mask     <= n_mask;
            r_status   <= n_status;
            r_obj_addr <= n_obj_addr;
            r_scroll   <= n_scroll;
            r_vaddr    <= n_vaddr;
            r_toggle   <= n_toggle;
            if (w_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (w_obj_we) begin
                r_obj_valid[w_obj_idx] <= 1'b1;
            end
            // entries at multiples of 4 write both halves of the palette
            if (w_pal_we) begin
                if (w_pal_mirror) begin
                    r_palette[{1'b0, w_pal_idx[PB-2:0]}] <= i_in.write_data;
                    r_palette[{1'b1, w_pal_idx[PB-2:0]}] <= i_in.write_data;
                end else begin
                    r_palette[w_pal_idx] <= i_in.write_data;
                end
            end
            // buffer reloads as the data-port result leaves, keeping item order
            if (w_out_take && (r_s1_sel == SEL_PORT)) begin
                r_read_buffer <= r_s1_flat ? w_vid_rdata : r_s1_pal;
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sel    <= n_s1_sel;
            r_s1_rd     <= n_s1_rd;
            r_s1_nmi    <= n_s1_nmi;
            r_s1_err    <= n_s1_err;
            r_s1_obj_ok <= n_s1_obj_ok;
            r_s1_flat   <= n_s1_flat;
            r_s1_pal    <= n_s1_pal;
        end
    end

    always_comb begin
        unique case (r_s1_sel)
            SEL_REG:  o_out.read_data = r_s1_rd;
            SEL_OBJ:  o_out.read_data = r_s1_obj_ok ? w_obj_rdata : 8'd0;
            SEL_PORT: o_out.read_data = r_read_buffer;
            default:  o_out.read_data = 8'd0;
        endcase
    end

    assign o_out.valid        = r_s1_valid;
    assign o_out.nmi_pulse    = r_s1_nmi;
    assign o_out.access_error = r_s1_err;

`ifndef SYNTH
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !w_accept)
        else $error("word accepted during video memory sweep");

    a_vblank_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick && w_evt.set_vblank && !w_evt.clr_vblank) |=>
            (r_status[ppu_rp_pkg::VBLANK_BIT] &&
             (r_s1_nmi == $past(r_control[ppu_rp_pkg::CTRL_NMI_BIT]))))
        else $error("vblank start did not set status or nmi");

    a_nmi_err_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.nmi_pulse && o_out.access_error))
        else $error("nmi and access error on one result");
`endif
endmodule

### tb/tb_top.sv
// Self-checking testbench for the video processor register port.
`timescale 1ns / 1ps

module tb_top;

    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 80000;     // covers the video memory sweep after reset
    localparam int LONG_HOLD      = 40;
    localparam int DRAIN_TAIL     = 8;
    localparam int RANDOM_WORDS   = 150;
    localparam int QUIET_WORDS    = 40;
    localparam int PRINT_LIMIT    = 100;
    localparam int TICK_WORDS     = ppu_rp_pkg::DOTS_PER_LINE + 4;   // crosses one line wrap

    localparam int VA = ppu_rp_pkg::VIDEO_ADDR_BITS;
    localparam int OB = ppu_rp_pkg::OBJ_IDX_BITS;
    localparam int PB = ppu_rp_pkg::PAL_IDX_BITS;

    localparam logic [1:0] MODE_NONE  = 2'd3;   // no operation
    localparam logic [7:0] NMI_ENABLE = 8'(1 << ppu_rp_pkg::CTRL_NMI_BIT);

    typedef struct {
        logic [1:0] mode;
        logic [2:0] reg_index;
        logic [7:0] read_data;
        logic       nmi_pulse;
        logic       access_error;
    } t_port_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ppu_rp_in_if  in_ch ();
    ppu_rp_out_if out_ch ();

    ppu_register_port_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the port state
    logic [7:0]  ctrl_q, mask_q, status_q, obj_addr_q, read_buf_q;
    logic [15:0] scroll_q, vaddr_q;
    logic        toggle_q;
    logic [7:0]  obj_mem [ppu_rp_pkg::OBJECT_DEPTH];
    logic [7:0]  pal_mem [ppu_rp_pkg::PALETTE_DEPTH];
    logic [7:0]  vram_mem [ppu_rp_pkg::VIDEO_DEPTH];
    int          dot_col, dot_row;

    t_port_result expected_results[$];

    int unsigned words_in, results_checked, nmi_seen, errors_seen, mismatch_count;
    int unsigned idle_cycles;
    bit          idle_on;
    bit          hold_request;

    function automatic t_port_result predict_port(logic [1:0] m, logic [2:0] r, logic [7:0] d);
        t_port_result res;
        logic [PB-1:0] pal_idx;
        logic [15:0] step;
        res = '{mode: m, reg_index: r, read_data: 8'h00, nmi_pulse: 1'b0, access_error: 1'b0};
        pal_idx = vaddr_q[PB-1:0];
        step = ctrl_q[ppu_rp_pkg::CTRL_STEP_BIT] ? ppu_rp_pkg::STEP_WIDE
                                                 : ppu_rp_pkg::STEP_NARROW;
        case (m)
            ppu_rp_pkg::MODE_READ: begin
                case (r)
                    ppu_rp_pkg::REG_CTRL: res.read_data = ctrl_q;
                    ppu_rp_pkg::REG_MASK: res.read_data = mask_q;
                    ppu_rp_pkg::REG_STATUS: begin
                        res.read_data = status_q;
                        status_q[ppu_rp_pkg::VBLANK_BIT] = 1'b0;
                        toggle_q = 1'b0;
                    end
                    ppu_rp_pkg::REG_OBJ_DATA: res.read_data = obj_mem[obj_addr_q[OB-1:0]];
                    ppu_rp_pkg::REG_DATA: begin
                        // buffered: return old buffer, refill from current address
                        res.read_data = read_buf_q;
                        if (vaddr_q < ppu_rp_pkg::PALETTE_BASE) begin
                            read_buf_q = vram_mem[vaddr_q[VA-1:0]];
                        end else if (vaddr_q < ppu_rp_pkg::VIDEO_LIMIT) begin
                            read_buf_q = pal_mem[pal_idx];
                        end else begin
                            read_buf_q = 8'h00;
                            res.access_error = 1'b1;
                        end
                        vaddr_q += step;
                    end
                    default: res.access_error = 1'b1;
                endcase
            end
            ppu_rp_pkg::MODE_WRITE: begin
                case (r)
                    ppu_rp_pkg::REG_CTRL:     ctrl_q = d;
                    ppu_rp_pkg::REG_MASK:     mask_q = d;
                    ppu_rp_pkg::REG_STATUS:   status_q = d;
                    ppu_rp_pkg::REG_OBJ_ADDR: obj_addr_q = d;
                    ppu_rp_pkg::REG_OBJ_DATA: begin
                        obj_mem[obj_addr_q[OB-1:0]] = d;
                        obj_addr_q += 8'd1;
                    end
                    ppu_rp_pkg::REG_SCROLL: begin
                        if (!toggle_q) scroll_q[15:8] = d;
                        else scroll_q[7:0] = d;
                        toggle_q = ~toggle_q;
                    end
                    ppu_rp_pkg::REG_VADDR: begin
                        if (!toggle_q) vaddr_q[15:8] = d;
                        else vaddr_q[7:0] = d;
                        toggle_q = ~toggle_q;
                    end
                    default: begin
                        if (vaddr_q < ppu_rp_pkg::PALETTE_BASE) begin
                            vram_mem[vaddr_q[VA-1:0]] = d;
                        end else if (vaddr_q < ppu_rp_pkg::VIDEO_LIMIT) begin
                            // backdrop entries mirror between the two halves
                            if (pal_idx[1:0] == 2'b00) begin
                                pal_mem[{1'b0, pal_idx[3:0]}] = d;
                                pal_mem[{1'b1, pal_idx[3:0]}] = d;
                            end else begin
                                pal_mem[pal_idx] = d;
                            end
                        end else begin
                            res.access_error = 1'b1;
                        end
                        vaddr_q += step;
                    end
                endcase
            end
            ppu_rp_pkg::MODE_TICK: begin
                dot_col++;
                if (dot_col >= ppu_rp_pkg::DOTS_PER_LINE) begin
                    dot_col = 0;
                    dot_row++;
                    if (dot_row >= ppu_rp_pkg::LINES_PER_FRAME) dot_row = 0;
                end
                if (dot_row == ppu_rp_pkg::VBLANK_LINE && dot_col == 1) begin
                    status_q[ppu_rp_pkg::VBLANK_BIT] = 1'b1;
                    res.nmi_pulse = ctrl_q[ppu_rp_pkg::CTRL_NMI_BIT];
                end
                if (dot_row == ppu_rp_pkg::LINES_PER_FRAME - 1 && dot_col == 1)
                    status_q[ppu_rp_pkg::VBLANK_BIT] = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) $display("mismatch at %0t: %s", $time, what);
    endtask

    // input monitor: predict every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            expected_results.push_back(predict_port(in_ch.mode, in_ch.reg_index,
                                                    in_ch.write_data));
            words_in++;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_port_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_checked++;
            if (out_ch.nmi_pulse === 1'b1) nmi_seen++;
            if (out_ch.access_error === 1'b1) errors_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing pending");
            end else begin
                want = expected_results.pop_front();
                if (out_ch.read_data !== want.read_data)
                    report_mismatch($sformatf("mode %0d reg %0d read_data %02h, want %02h",
                        want.mode, want.reg_index, out_ch.read_data, want.read_data));
                if (out_ch.nmi_pulse !== want.nmi_pulse)
                    report_mismatch($sformatf("mode %0d reg %0d nmi_pulse %b, want %b",
                        want.mode, want.reg_index, out_ch.nmi_pulse, want.nmi_pulse));
                if (out_ch.access_error !== want.access_error)
                    report_mismatch($sformatf("mode %0d reg %0d access_error %b, want %b",
                        want.mode, want.reg_index, out_ch.access_error, want.access_error));
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (hold_request) begin
                out_ch.ready <= 1'b0;
                stall_left = LONG_HOLD - 1;
                hold_request = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] m, input logic [2:0] r, input logic [7:0] d);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= m;
        in_ch.reg_index  <= r;
        in_ch.write_data <= d;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_video_addr(input logic [15:0] a);
        send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_STATUS, 8'h00);   // clears the toggle
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_VADDR, a[15:8]);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_VADDR, a[7:0]);
    endtask

    function automatic logic [15:0] pick_video_addr();
        case ($urandom_range(0, 5))
            0, 1:    return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 31))};
            2:       return ppu_rp_pkg::PALETTE_BASE - 16'($urandom_range(1, 32));
            3:       return ppu_rp_pkg::PALETTE_BASE | 16'($urandom_range(0, 255));
            4:       return ppu_rp_pkg::VIDEO_LIMIT - 16'($urandom_range(1, 32));
            default: return ppu_rp_pkg::VIDEO_LIMIT + 16'($urandom_range(0, 16'hBFFF));
        endcase
    endfunction

    task automatic test_register_file();
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_CTRL, 8'hFF);
        send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_CTRL, 8'h00);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_MASK, 8'hA5);
        send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_MASK, 8'hFF);
        // object address wraps past the top entry
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_OBJ_ADDR, 8'hFF);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_OBJ_DATA, 8'h5A);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_OBJ_ADDR, 8'hFF);
        send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_OBJ_DATA, 8'h00);
        // write-only registers
        send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_OBJ_ADDR, 8'h00);
        send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_SCROLL, 8'h00);
        send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_VADDR, 8'h00);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_SCROLL, 8'h12);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_SCROLL, 8'h34);
        send_word(MODE_NONE, ppu_rp_pkg::REG_DATA, 8'hFF);
    endtask

    task automatic test_data_port();
        // control still has step 32 set
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_VADDR, 8'h3F);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_VADDR, 8'h10);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_DATA, 8'h3C);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_CTRL, 8'h00);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_VADDR, 8'h3F);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_VADDR, 8'h00);
        send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_DATA, 8'h00);
        send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_DATA, 8'h00);
        // top of the address space, then wrap to zero
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_VADDR, 8'hFF);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_VADDR, 8'hFF);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_DATA, 8'h00);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_VADDR, 8'h40);
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_VADDR, 8'h00);
        send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_DATA, 8'h00);
    endtask

    // dot ticks across one line wrap with NMI on; status peeks at random
    task automatic test_frame_timing();
        int unsigned next_peek;
        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_CTRL, NMI_ENABLE);
        next_peek = $urandom_range(1, 100);
        for (int t = 0; t < TICK_WORDS; t++) begin
            send_word(ppu_rp_pkg::MODE_TICK, 3'($urandom), 8'($urandom));
            if (t == next_peek) begin
                send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_STATUS, 8'h00);
                next_peek += $urandom_range(1, 100);
            end
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_request = 1'b1;
        for (int i = 0; i < 16; i++) begin
            if (i % 2 == 0) send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_MASK, 8'($urandom));
            else send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_MASK, 8'h00);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned stop_at;
        int unsigned burst;
        logic [7:0]  obj_base;
        logic [2:0]  cfg_reg;
        stop_at = words_in + RANDOM_WORDS;
        while (words_in < stop_at) begin
            if (stop_at - words_in < QUIET_WORDS) idle_on = 1'b0;
            burst = $urandom_range(1, 6);
            case ($urandom_range(0, 9))
                0, 1: begin
                    set_video_addr(pick_video_addr());
                    repeat (burst)
                        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_DATA, 8'($urandom));
                end
                2, 3: begin
                    set_video_addr(pick_video_addr());
                    repeat (burst + 1)
                        send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_DATA, 8'($urandom));
                end
                4: begin
                    obj_base = 8'($urandom);
                    send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_OBJ_ADDR, obj_base);
                    repeat (burst)
                        send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_OBJ_DATA,
                                  8'($urandom));
                    send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_OBJ_ADDR,
                              obj_base + 8'($urandom_range(0, burst - 1)));
                    send_word(ppu_rp_pkg::MODE_READ, ppu_rp_pkg::REG_OBJ_DATA, 8'($urandom));
                end
                5: repeat ($urandom_range(1, 3))
                    send_word(ppu_rp_pkg::MODE_WRITE, ppu_rp_pkg::REG_SCROLL, 8'($urandom));
                6: begin
                    case ($urandom_range(0, 2))
                        0:       cfg_reg = ppu_rp_pkg::REG_CTRL;
                        1:       cfg_reg = ppu_rp_pkg::REG_MASK;
                        default: cfg_reg = ppu_rp_pkg::REG_STATUS;
                    endcase
                    send_word(ppu_rp_pkg::MODE_WRITE, cfg_reg, 8'($urandom));
                    send_word(ppu_rp_pkg::MODE_READ, cfg_reg, 8'($urandom));
                end
                7: repeat (burst * 3)
                    send_word(ppu_rp_pkg::MODE_TICK, 3'($urandom), 8'($urandom));
                default: repeat (burst) send_word(2'($urandom), 3'($urandom), 8'($urandom));
            endcase
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= ppu_rp_pkg::MODE_READ;
        in_ch.reg_index  <= ppu_rp_pkg::REG_CTRL;
        in_ch.write_data <= 8'h00;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        ctrl_q = '0; mask_q = '0; status_q = '0; obj_addr_q = '0; read_buf_q = '0;
        scroll_q = '0; vaddr_q = '0; toggle_q = 1'b0;
        dot_col = 0; dot_row = 0;
        for (int i = 0; i < ppu_rp_pkg::OBJECT_DEPTH; i++) obj_mem[i] = '0;
        for (int i = 0; i < ppu_rp_pkg::PALETTE_DEPTH; i++) pal_mem[i] = '0;
        for (int i = 0; i < ppu_rp_pkg::VIDEO_DEPTH; i++) vram_mem[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_file();
        test_data_port();
        test_backpressure();
        test_frame_timing();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        $display("run: %0d words sent, %0d results checked, dot ticks past one line wrap",
                 words_in, results_checked);
        $display("run: %0d nmi pulses, %0d access errors, %0d mismatches",
                 nmi_seen, errors_seen, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/ppu_rp_pkg.sv
rtl/ppu_rp_if.sv
rtl/ppu_rp_ram.sv
rtl/ppu_rp_timing.sv
rtl/ppu_register_port_top.sv
tb/tb_top.sv
